/* rtl/dtq_pkg.sv */
// dtq_pkg: types, constants and control structs for the deadline task queue
// used by dtq_ctrl, dtq_datapath and deadline_task_queue; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dtq_pkg;

  localparam int unsigned SLOTS     = 16;
  localparam int unsigned IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned TAG_W     = 16;

  typedef enum logic [1:0] {
    OP_INS_ABS = 2'd0,
    OP_INS_REL = 2'd1,
    OP_POLL    = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_FIRED    = 3'd0,
    ST_ACCEPTED = 3'd1,
    ST_FULL     = 3'd2,
    ST_TOO_LONG = 3'd3,
    ST_NONE_DUE = 3'd4
  } status_e;

  typedef struct packed {
    op_e               operation;
    logic [TIME_W-1:0] time_value;
    logic [TIME_W-1:0] now_ms;
    logic [TAG_W-1:0]  task_tag;
  } in_item_t;

  typedef struct packed {
    logic [TAG_W-1:0] out_tag;
    status_e          status;
    logic             last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic insert;
    logic start_poll;
    logic step;
    logic flush;
  } dtq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic pend_valid;
    logic idx_last;
    logic out_free;
  } dtq_stat_t;

endpackage

`default_nettype wire

/* rtl/dtq_datapath.sv */
// dtq_datapath: slot file, scan index, pending fired word and output register
// depends on dtq_pkg; driven by dtq_ctrl through dtq_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module dtq_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dtq_pkg::in_item_t  in_item_i,
  input  wire dtq_pkg::dtq_cmd_t  cmd_i,
  output dtq_pkg::dtq_stat_t      stat_o,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output dtq_pkg::out_item_t      out_item_o
);
  import dtq_pkg::*;

  logic [SLOTS-1:0]  valid_q, valid_d;
  logic [TIME_W-1:0] due_q [SLOTS];
  logic [TAG_W-1:0]  tag_q [SLOTS];

  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [TIME_W-1:0] now_q;
  logic              pend_valid_q, pend_valid_d;
  logic [TAG_W-1:0]  pend_tag_q;

  logic              out_valid_q, out_valid_d;
  out_item_t         out_item_q, out_item_d;
  logic              out_load;

  logic [IDX_W-1:0]  free_idx;
  logic              free_found;
  logic              too_long;
  logic [TIME_W-1:0] ins_due;
  logic              ins_write;
  logic [TIME_W-1:0] diff;
  logic              hit;

  // lowest-numbered free slot
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx   = IDX_W'(i);
        free_found = 1'b1;
      end
    end
  end

  assign too_long  = (in_item_i.operation == OP_INS_REL) && in_item_i.time_value[TIME_W-1];
  assign ins_due   = (in_item_i.operation == OP_INS_REL) ?
                     in_item_i.now_ms + in_item_i.time_value : in_item_i.time_value;
  assign ins_write = cmd_i.insert && !too_long && free_found;

  // wrap-aware compare: due when now - due is non-negative
  assign diff = now_q - due_q[idx_q];
  assign hit  = valid_q[idx_q] && !diff[TIME_W-1];

  always_comb begin
    valid_d = valid_q;
    if (ins_write) valid_d[free_idx] = 1'b1;
    if (cmd_i.step && hit) valid_d[idx_q] = 1'b0;
  end

  always_comb begin
    idx_d        = idx_q;
    pend_valid_d = pend_valid_q;
    if (cmd_i.start_poll) begin
      idx_d        = '0;
      pend_valid_d = 1'b0;
    end else if (cmd_i.step) begin
      idx_d = idx_q + 1'b1;
      if (hit) pend_valid_d = 1'b1;
    end else if (cmd_i.flush) begin
      pend_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_load   = 1'b0;
    out_item_d = out_item_q;
    if (cmd_i.insert) begin
      out_load           = 1'b1;
      out_item_d.out_tag = '0;
      out_item_d.last    = 1'b1;
      if (too_long)        out_item_d.status = ST_TOO_LONG;
      else if (!free_found) out_item_d.status = ST_FULL;
      else                 out_item_d.status = ST_ACCEPTED;
    end else if (cmd_i.step && hit && pend_valid_q) begin
      // a later slot fired too, so the held word is not the final one
      out_load   = 1'b1;
      out_item_d = '{out_tag: pend_tag_q, status: ST_FIRED, last: 1'b0};
    end else if (cmd_i.flush) begin
      out_load = 1'b1;
      if (pend_valid_q) out_item_d = '{out_tag: pend_tag_q, status: ST_FIRED, last: 1'b1};
      else              out_item_d = '{out_tag: '0, status: ST_NONE_DUE, last: 1'b1};
    end
  end

  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      valid_q      <= valid_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins_write) begin
      due_q[free_idx] <= ins_due;
      tag_q[free_idx] <= in_item_i.task_tag;
    end
    if (cmd_i.start_poll) now_q <= in_item_i.now_ms;
    if (cmd_i.step && hit) pend_tag_q <= tag_q[idx_q];
    if (out_load) out_item_q <= out_item_d;
  end

  assign stat_o.hit        = hit;
  assign stat_o.pend_valid = pend_valid_q;
  assign stat_o.idx_last   = (idx_q == IDX_W'(SLOTS - 1));
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

/* rtl/dtq_ctrl.sv */
// dtq_ctrl: sequencer for insert and poll words of the deadline task queue
// depends on dtq_pkg; commands dtq_datapath
`timescale 1ns / 1ps
`default_nettype none

module dtq_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire dtq_pkg::op_e       operation_i,
  input  wire dtq_pkg::dtq_stat_t stat_i,
  output dtq_pkg::dtq_cmd_t       cmd_o
);
  import dtq_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;
  logic       stall;

  assign accept = in_valid_i && stat_i.out_free && (state_q == S_IDLE);
  // a second hit needs the output register for the held word
  assign stall  = stat_i.hit && stat_i.pend_valid && !stat_i.out_free;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = stat_i.out_free;
        if (accept) begin
          case (operation_i)
            OP_INS_ABS, OP_INS_REL: cmd_o.insert = 1'b1;
            OP_POLL: begin
              cmd_o.start_poll = 1'b1;
              state_d          = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (!stall) begin
          cmd_o.step = 1'b1;
          if (stat_i.idx_last) state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (stat_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/deadline_task_queue.sv */
// deadline_task_queue: top level joining the sequencer and the slot datapath
// depends on dtq_pkg, dtq_ctrl and dtq_datapath
//
// Usage: one input channel (in_valid_i / in_ready_o handshake, in_item_i word) carries
// inserts and polls; one output channel (out_valid_o / out_ready_i, out_item_o)
// returns result words. An insert (absolute or relative) gives one status word
// in the cycle after it is taken. A poll walks the SLOTS slots one per cycle
// unless a held fired word must wait for the receiver, then a flush state sends
// the final word; each due slot gives one fired word, the final word of a poll
// has last set, and a poll with nothing due gives a single none-due word.
// Unused operation codes are taken and dropped.
// A new word is taken only when the block is idle and the output register is
// empty or being drained. If the receiver stalls, the slot walk pauses on the
// next due slot until the held fired word can move. Reset empties the pool and
// the output register at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module deadline_task_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire dtq_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output dtq_pkg::out_item_t      out_item_o
);
  import dtq_pkg::*;

  dtq_cmd_t  cmd;
  dtq_stat_t stat;

  dtq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (in_item_i.operation),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dtq_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

/* verif/deadline_task_queue_test.sv */
// deadline_task_queue_test: self-checking bench for the deadline task queue
// keeps its own copy of the slot pool to predict fired, accepted and status words
// depends on dtq_pkg and deadline_task_queue
`timescale 1ns / 1ps

module deadline_task_queue_test;
  import dtq_pkg::*;

  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 220;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  class due_pool_scoreboard;
    localparam logic [TIME_W-1:0] MAX_DELAY = 16'd32767;

    bit                in_use [SLOTS];
    logic [TIME_W-1:0] due_ms [SLOTS];
    logic [TAG_W-1:0]  slot_tag [SLOTS];
    out_item_t         expected_words [$];
    int unsigned       mismatches;
    int unsigned       seen;

    function out_item_t make_word(logic [TAG_W-1:0] tag, status_e st, logic fin);
      out_item_t r;
      r.out_tag = tag;
      r.status  = st;
      r.last    = fin;
      return r;
    endfunction

    function void store_task(logic [TIME_W-1:0] due, logic [TAG_W-1:0] tag);
      bit placed;
      placed = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        if (!placed && !in_use[i]) begin
          in_use[i]   = 1'b1;
          due_ms[i]   = due;
          slot_tag[i] = tag;
          placed      = 1'b1;
        end
      end
      expected_words.push_back(make_word('0, placed ? ST_ACCEPTED : ST_FULL, 1'b1));
    endfunction

    function void note_request(in_item_t w);
      logic [TIME_W-1:0] due;
      logic [TIME_W-1:0] diff;
      int                fired;
      fired = 0;
      case (w.operation)
        OP_INS_ABS: store_task(w.time_value, w.task_tag);
        OP_INS_REL: begin
          if (w.time_value > MAX_DELAY) begin
            expected_words.push_back(make_word('0, ST_TOO_LONG, 1'b1));
          end else begin
            due = w.now_ms + w.time_value;
            store_task(due, w.task_tag);
          end
        end
        OP_POLL: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (in_use[i]) begin
              // wrap-aware: due when now - due is not negative
              diff = w.now_ms - due_ms[i];
              if (!diff[TIME_W-1]) begin
                in_use[i] = 1'b0;
                expected_words.push_back(make_word(slot_tag[i], ST_FIRED, 1'b0));
                fired++;
              end
            end
          end
          if (fired == 0) begin
            expected_words.push_back(make_word('0, ST_NONE_DUE, 1'b1));
          end else begin
            expected_words[expected_words.size()-1].last = 1'b1;
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("[%0t] mismatch on result %0d: %s", $time, seen, msg);
      mismatches++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      seen++;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word tag %h status %0d last %b",
                         got.out_tag, got.status, got.last));
        return;
      end
      want = expected_words.pop_front();
      if (got.out_tag !== want.out_tag)
        report($sformatf("out_tag %h, want %h", got.out_tag, want.out_tag));
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.last !== want.last)
        report($sformatf("last %b, want %b", got.last, want.last));
    endtask
  endclass

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  in_item_t    in_item   = '0;
  logic        out_ready = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  out_item_t   out_item_o;

  due_pool_scoreboard board = new();

  int unsigned       ready_left   = 0;
  int unsigned       cycle_count  = 0;
  int unsigned       no_gap_left  = 0;
  logic [TIME_W-1:0] clock_ms     = '0;

  deadline_task_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_o  (out_item_o)
  );

  always #1 clk_i = ~clk_i;

  // mostly short gaps, a few long ones
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t make_request(logic [1:0] op, logic [TIME_W-1:0] tv,
                                            logic [TIME_W-1:0] now, logic [TAG_W-1:0] tag);
    in_item_t w;
    w.operation  = op_e'(op);
    w.time_value = tv;
    w.now_ms     = now;
    w.task_tag   = tag;
    return w;
  endfunction

  // receiver: alternating stalls and runs, some runs long enough to never idle
  always @(posedge clk_i) begin
    if (ready_left != 0) begin
      ready_left <= ready_left - 1;
    end else if (out_ready) begin
      out_ready  <= 1'b0;
      ready_left <= idle_len();
    end else begin
      out_ready  <= 1'b1;
      ready_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(0, 6);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) board.check_result(out_item_o);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_request(input in_item_t w);
    int unsigned gap;
    in_valid <= 1'b1;
    in_item  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_request(w);
    if (no_gap_left != 0) begin
      gap = 0;
      no_gap_left--;
    end else begin
      gap = idle_len();
      if ($urandom_range(0, 19) == 0) no_gap_left = $urandom_range(10, 30);
    end
    // valid stays high across back-to-back words
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (board.expected_words.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned       count;
    int unsigned       roll;
    int unsigned       fill_left;
    logic [TIME_W-1:0] tv;
    logic [TIME_W-1:0] now;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty poll, field extremes, delay limit, wrap, full pool
    send_request(make_request(OP_POLL, 16'h0000, 16'h0000, 16'h0000));
    send_request(make_request(OP_INS_ABS, 16'hFFFF, 16'h0000, 16'hFFFF));
    send_request(make_request(OP_INS_ABS, 16'h0000, 16'hFFFF, 16'h0000));
    send_request(make_request(OP_INS_REL, 16'h7FFF, 16'h8001, 16'h8000));
    send_request(make_request(OP_INS_REL, 16'h8000, 16'h0000, 16'h1111));
    send_request(make_request(OP_INS_REL, 16'hFFFF, 16'hFFFF, 16'h2222));
    send_request(make_request(OP_INS_REL, 16'h0000, 16'h1234, 16'h5555));
    send_request(make_request(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_request(make_request(OP_POLL, 16'hFFFF, 16'h0000, 16'hFFFF));
    for (int i = 0; i < SLOTS - 1; i++) begin
      send_request(make_request(OP_INS_ABS, 16'(16'h8000 + i), 16'h0000,
                                16'(16'hA5A0 ^ i)));
    end
    send_request(make_request(OP_INS_ABS, 16'h0000, 16'h0000, 16'h7777));
    // too-long wins over pool full
    send_request(make_request(OP_INS_REL, 16'h8000, 16'h0000, 16'h6666));
    send_request(make_request(OP_POLL, 16'h0000, 16'h7FFF, 16'h0000));
    send_request(make_request(OP_POLL, 16'h0000, 16'hFFFF, 16'h0000));
    send_request(make_request(OP_POLL, 16'h0000, 16'h0000, 16'h0000));
    wait_drained();

    count     = 0;
    fill_left = 0;
    clock_ms  = 16'($urandom);
    while (count < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (fill_left != 0) begin
        fill_left--;
        tv = 16'($urandom_range(0, 100));
        send_request(make_request(OP_INS_REL, tv, clock_ms, 16'($urandom)));
        count++;
      end else if (roll < 40) begin
        roll = $urandom_range(0, 99);
        if (roll < 85) tv = 16'($urandom_range(0, 200));
        else if (roll < 95) tv = 16'($urandom_range(0, 32767));
        else tv = 16'($urandom_range(32768, 65535));
        send_request(make_request(OP_INS_REL, tv, clock_ms, 16'($urandom)));
        count++;
      end else if (roll < 55) begin
        tv = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                         : 16'(clock_ms + $urandom_range(0, 300));
        send_request(make_request(OP_INS_ABS, tv, 16'($urandom), 16'($urandom)));
        count++;
      end else if (roll < 90) begin
        clock_ms = clock_ms + 16'($urandom_range(0, 150));
        now = ($urandom_range(0, 9) == 0) ? 16'($urandom) : clock_ms;
        send_request(make_request(OP_POLL, 16'($urandom), now, 16'($urandom)));
        count++;
      end else if (roll < 95) begin
        // ignored code, does not count
        send_request(make_request(OP_UNUSED, 16'($urandom), 16'($urandom),
                                  16'($urandom)));
      end else begin
        fill_left = $urandom_range(8, 18);
      end
      if (count == RANDOM_ITEMS / 2 || $urandom_range(0, 39) == 0) wait_drained();
    end

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (board.expected_words.size() != 0) @(posedge clk_i);
    repeat (4 * SLOTS) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
